// ===== hdl/aepd_pkg.sv =====
// ----------------------------------------------------------------------------
// aepd_pkg
// shared constants, types and scaling function of the attitude frame decoder
// ----------------------------------------------------------------------------
package aepd_pkg;

	localparam logic [7:0]  SYNC_BYTE  = 8'd49;
	localparam logic [4:0]  FIRST_POS  = 5'd1;
	localparam logic [4:0]  LAST_POS   = 5'd22;
	localparam int          WORD_CNT   = 10;
	localparam int          IDX_W      = $clog2(WORD_CNT);
	localparam logic [16:0] RATE_MUL   = 17'd62338;
	localparam logic [16:0] ACCEL_MUL  = 17'd35159;
	localparam logic [15:0] DECL_RESET = 16'hFA6B;

	// word slots inside a frame
	localparam int W_ROLL    = 0;
	localparam int W_PITCH   = 1;
	localparam int W_YAW     = 2;
	localparam int W_ACC_X   = 3;
	localparam int W_ACC_Y   = 4;
	localparam int W_ACC_Z   = 5;
	localparam int W_RATE_X  = 6;
	localparam int W_RATE_Y  = 7;
	localparam int W_RATE_Z  = 8;
	localparam int W_TIMER   = 9;

	typedef logic [WORD_CNT-1:0][15:0] words_t;

	typedef struct packed {
		logic   done;
		words_t words;
	} frame_t;

	// floor(raw * mul / 65536) for a signed raw word
	function automatic logic [15:0] scale_word(input logic [15:0] w, input logic [16:0] mul);
		logic signed [33:0] p;
		p = $signed({{18{w[15]}}, w}) * $signed({17'd0, mul});
		return p[31:16];
	endfunction

endpackage

// ===== hdl/aepd_framer.sv =====
// ----------------------------------------------------------------------------
// aepd_framer
// input register, sync hunt, word assembly, running sum and checksum test
// ----------------------------------------------------------------------------
module aepd_framer import aepd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        res_free,
	output frame_t      frame
);

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             in_frame_q;
	logic [4:0]       pos_q;
	logic [15:0]      sum_q;
	logic [7:0]       hi_q;
	words_t           words_q;

	logic [15:0]      word;
	logic [IDX_W-1:0] idx;
	logic             is_last;
	logic             good;
	logic             adv;

	assign word    = {hi_q, byte_s1};
	assign idx     = pos_q[IDX_W:1] - IDX_W'(1);
	assign is_last = in_frame_q && !pos_q[0] && (pos_q == LAST_POS);
	assign good    = vld_s1 && is_last && (word == sum_q);
	assign adv     = vld_s1 && (!good || res_free);
	assign in_ready = !vld_s1 || adv;

	assign frame.done  = adv && good;
	assign frame.words = words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			sum_q      <= '0;
		end else if (adv) begin
			if (!in_frame_q) begin
				if (byte_s1 == SYNC_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= FIRST_POS;
					sum_q      <= {8'd0, SYNC_BYTE};
				end
			end else if (pos_q[0]) begin
				pos_q <= pos_q + 5'd1;
			end else if (pos_q != LAST_POS) begin
				sum_q <= sum_q + word;
				pos_q <= pos_q + 5'd1;
			end else begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				sum_q      <= '0;
			end
		end
	end

	// payload holders, no reset
	always_ff @(posedge clk) begin
		if (adv && in_frame_q) begin
			if (pos_q[0]) begin
				hi_q <= byte_s1;
			end else if (pos_q != LAST_POS) begin
				for (int i = 0; i < WORD_CNT; i++) begin
					if (idx == IDX_W'(i)) begin
						words_q[i] <= word;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/aepd_scale.sv =====
// ----------------------------------------------------------------------------
// aepd_scale
// fixed-point scaling of a good frame's rates and accels, with the heading offset
// by the declination and the angles and timer copied, into the result register
module aepd_scale import aepd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic [15:0] decl,
	output logic        res_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] roll_angle,
	output logic [15:0] pitch_angle,
	output logic [15:0] heading,
	output logic [15:0] roll_rate,
	output logic [15:0] pitch_rate,
	output logic [15:0] yaw_rate,
	output logic [15:0] roll_accel,
	output logic [15:0] pitch_accel,
	output logic [15:0] yaw_accel,
	output logic [15:0] timer_ticks
);

	assign res_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (frame.done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			roll_angle  <= frame.words[W_ROLL];
			pitch_angle <= frame.words[W_PITCH];
			heading     <= frame.words[W_YAW] + decl;
			roll_rate   <= scale_word(frame.words[W_RATE_X], RATE_MUL);
			pitch_rate  <= scale_word(frame.words[W_RATE_Y], RATE_MUL);
			yaw_rate    <= scale_word(frame.words[W_RATE_Z], RATE_MUL);
			roll_accel  <= scale_word(frame.words[W_ACC_X], ACCEL_MUL);
			pitch_accel <= scale_word(frame.words[W_ACC_Y], ACCEL_MUL);
			yaw_accel   <= scale_word(frame.words[W_ACC_Z], ACCEL_MUL);
			timer_ticks <= frame.words[W_TIMER];
		end
	end

endmodule

// ===== hdl/ahrs_euler_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// ahrs_euler_packet_decoder
// decodes sync-led 23-byte attitude frames into angles, scaled rates, accels
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | data_byte
//  out     | out_valid/ out_ready | roll_angle .. timer_ticks (ten words)
//  cfg     | cfg_valid/ cfg_ready | cfg_data (declination)
//
//  one byte item per cycle while in_ready is high; a good frame's last
//  byte enters the input register, then its result the result register
//  reset clears frame state and loads declination with -1429
//  in_ready drops only when a finished frame meets a stalled result
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module ahrs_euler_packet_decoder import aepd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] roll_angle,
	output logic [15:0] pitch_angle,
	output logic [15:0] heading,
	output logic [15:0] roll_rate,
	output logic [15:0] pitch_rate,
	output logic [15:0] yaw_rate,
	output logic [15:0] roll_accel,
	output logic [15:0] pitch_accel,
	output logic [15:0] yaw_accel,
	output logic [15:0] timer_ticks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] decl_q;
	logic        res_free;
	frame_t      frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			decl_q <= cfg_data;
		end
	end

	aepd_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.res_free  (res_free),
		.frame     (frame)
	);

	aepd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.decl        (decl_q),
		.res_free    (res_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.heading     (heading),
		.roll_rate   (roll_rate),
		.pitch_rate  (pitch_rate),
		.yaw_rate    (yaw_rate),
		.roll_accel  (roll_accel),
		.pitch_accel (pitch_accel),
		.yaw_accel   (yaw_accel),
		.timer_ticks (timer_ticks)
	);

endmodule

// ===== hdl/aepd_checker.sv =====
// ----------------------------------------------------------------------------
// aepd_checker
// port-level checks of the attitude frame decoder
// ----------------------------------------------------------------------------
module aepd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] roll_angle,
	input logic [15:0] pitch_angle,
	input logic [15:0] heading,
	input logic [15:0] roll_rate,
	input logic [15:0] pitch_rate,
	input logic [15:0] yaw_rate,
	input logic [15:0] roll_accel,
	input logic [15:0] pitch_accel,
	input logic [15:0] yaw_accel,
	input logic [15:0] timer_ticks
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable(roll_angle) && $stable(pitch_angle) && $stable(heading)
		&& $stable(roll_rate) && $stable(pitch_rate) && $stable(yaw_rate)
		&& $stable(roll_accel) && $stable(pitch_accel) && $stable(yaw_accel)
		&& $stable(timer_ticks))
		else $error("stalled result changed");

	// input side stalls only behind a blocked result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a rising out_valid only follows an edge where in_ready was high
	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared without input progress");

endmodule

bind ahrs_euler_packet_decoder aepd_checker u_aepd_checker (.*);
